// File: src/sbdph_pkg.sv
// Shared types and constants of the spectrum bin dB peak-hold block.
`timescale 1ns / 1ps
`default_nettype none

package sbdph_pkg;

    // Item field widths
    localparam int IDX_W      = 10;
    localparam int Q15_W      = 16;
    localparam int FFT_LOG2_W = 5;
    localparam int DECAY_W    = 15;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH   = 2'd0,
        CFG_FFT_LOG2 = 2'd1,
        CFG_DECAY    = 2'd2
    } t_cfg_reg;

    localparam logic                  RST_SMOOTH   = 1'b0;
    localparam logic [FFT_LOG2_W-1:0] RST_FFT_LOG2 = 5'd11;
    localparam logic [DECAY_W-1:0]    RST_DECAY    = 15'd262;

    // Q15 end points
    localparam logic signed [Q15_W-1:0] Q15_MINUS_ONE = 16'sh8000;
    localparam logic signed [Q15_W-1:0] Q15_PLUS_ONE  = 16'sh7FFF;

    // log2 in Q16: six integer bits cover both the msb position and 2*fft_length_log2
    localparam int L2_INT_W  = 6;
    localparam int FRAC_W    = 16;
    localparam int L2_W      = L2_INT_W + FRAC_W;
    localparam int MANT_W    = 32;
    localparam int LOG_STEPS = FRAC_W;

    // log10(2)/6 * 2^32, turns a log2 distance in Q16 into Q15 units of 60 dB / 2
    localparam int COEF_W = 28;
    localparam logic [COEF_W-1:0] LOG_COEF = 28'd215485664;
    localparam int PROD_W = L2_W + COEF_W;
    localparam int DELTA_W = PROD_W - 32;

    // Result item: out_index, level, peak from the lowest bit up
    localparam int OUT_W       = IDX_W + 2 * Q15_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Output queue
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;
    localparam int USED_W     = FIFO_AW + 1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] idx;
    } t_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

`default_nettype wire

// File: src/sbdph_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sbdph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/sbdph_db.sv
// Pipeline from a complex bin to its clamped dB level in Q15.
`timescale 1ns / 1ps
`default_nettype none

module sbdph_db #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire sbdph_pkg::t_ctl                     i_ctl,
    input  wire logic [SAMPLE_WIDTH-1:0]             i_re,
    input  wire logic [SAMPLE_WIDTH-1:0]             i_im,
    input  wire logic [sbdph_pkg::FFT_LOG2_W-1:0]    i_fft_log2,
    output logic                                     o_ahead_valid,
    output sbdph_pkg::t_ctl                          o_ahead_ctl,
    output logic                                     o_valid,
    output sbdph_pkg::t_ctl                          o_ctl,
    output logic signed [sbdph_pkg::Q15_W-1:0]       o_scaled
);

    import sbdph_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int P_W  = 2 * SW;
    localparam int E_W  = $clog2(P_W);
    localparam int NW   = (P_W > MANT_W) ? P_W : MANT_W;
    localparam int SH_W = $clog2(NW);

    // Stage 1: magnitudes of both parts
    logic          r_v1;
    t_ctl          r_c1;
    logic [SW-1:0] r_abs_re, r_abs_im;
    // Stage 2: squares
    logic           r_v2;
    t_ctl           r_c2;
    logic [P_W-1:0] r_sq_re, r_sq_im;
    // Stage 3: power
    logic           r_v3;
    t_ctl           r_c3;
    logic [P_W-1:0] r_p;
    // Stage 4: msb position
    logic           r_v4;
    t_ctl           r_c4;
    logic [P_W-1:0] r_p4;
    logic [E_W-1:0] r_e4;
    logic           r_z4;
    logic [E_W-1:0] n_e4;

    // Squaring chain; index 0 holds the normalized mantissa
    logic              r_sv   [LOG_STEPS+1];
    t_ctl              r_sc   [LOG_STEPS+1];
    logic [MANT_W-1:0] r_y    [LOG_STEPS+1];
    logic [E_W-1:0]    r_se   [LOG_STEPS+1];
    logic              r_sz   [LOG_STEPS+1];
    logic [FRAC_W-1:0] r_frac [LOG_STEPS+1];

    logic [NW-1:0]   n_norm;
    logic [SH_W-1:0] n_shift;

    // Stage after the chain: distance below full scale
    logic            r_v22;
    t_ctl            r_c22;
    logic            r_z22, r_ge22;
    logic [L2_W-1:0] r_t22;
    logic [L2_W-1:0] n_l2, n_ref;
    // Coefficient product
    logic              r_v23;
    t_ctl              r_c23;
    logic              r_z23, r_ge23;
    logic [PROD_W-1:0] r_prod23;
    // Output
    logic              r_v24;
    t_ctl              r_c24;
    logic signed [Q15_W-1:0] r_s24;
    logic [PROD_W-1:0]  n_round;
    logic [DELTA_W-1:0] n_delta;
    logic signed [Q15_W-1:0] n_s24;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_sv[0]  <= 1'b0;
            r_v22    <= 1'b0;
            r_v23    <= 1'b0;
            r_v24    <= 1'b0;
        end else begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_sv[0]  <= r_v4;
            r_v22    <= r_sv[LOG_STEPS];
            r_v23    <= r_v22;
            r_v24    <= r_v23;
        end
    end

    always_comb begin
        n_e4 = '0;
        for (int i = 0; i < P_W; i++) begin
            if (r_p[i]) begin
                n_e4 = E_W'(i);
            end
        end
    end

    // Left-justify the power so that its msb lands on the top mantissa bit
    always_comb begin
        n_shift = SH_W'(NW - 1) - SH_W'(r_e4);
        n_norm  = NW'(r_p4) << n_shift;
    end

    always_ff @(posedge i_clk) begin
        r_c1     <= i_ctl;
        r_abs_re <= i_re[SW-1] ? (~i_re + 1'b1) : i_re;
        r_abs_im <= i_im[SW-1] ? (~i_im + 1'b1) : i_im;

        r_c2    <= r_c1;
        r_sq_re <= P_W'(r_abs_re) * P_W'(r_abs_re);
        r_sq_im <= P_W'(r_abs_im) * P_W'(r_abs_im);

        r_c3 <= r_c2;
        r_p  <= r_sq_re + r_sq_im;

        r_c4 <= r_c3;
        r_p4 <= r_p;
        r_e4 <= n_e4;
        r_z4 <= (r_p == '0);

        r_sc[0]   <= r_c4;
        r_y[0]    <= n_norm[NW-1 -: MANT_W];
        r_se[0]   <= r_e4;
        r_sz[0]   <= r_z4;
        r_frac[0] <= '0;
    end

    // Each step squares the mantissa in [1,2) and yields one fraction bit of log2
    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_step
        logic [2*MANT_W-1:0] n_sq;
        logic [MANT_W:0]     n_q;

        always_comb begin
            n_sq = (2*MANT_W)'(r_y[k]) * (2*MANT_W)'(r_y[k]);
            n_q  = n_sq[2*MANT_W-1 -: MANT_W+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sc[k+1]   <= r_sc[k];
            r_se[k+1]   <= r_se[k];
            r_sz[k+1]   <= r_sz[k];
            r_y[k+1]    <= n_q[MANT_W] ? n_q[MANT_W:1] : n_q[MANT_W-1:0];
            r_frac[k+1] <= r_frac[k] | (FRAC_W'(n_q[MANT_W]) << (FRAC_W - 1 - k));
        end
    end

    always_comb begin
        n_l2  = {L2_INT_W'(r_se[LOG_STEPS]), r_frac[LOG_STEPS]};
        n_ref = {L2_INT_W'({i_fft_log2, 1'b0}), FRAC_W'(0)};
    end

    always_comb begin
        n_round = r_prod23 + (PROD_W'(1) << 31);
        n_delta = n_round[PROD_W-1 -: DELTA_W];
        if (r_z23) begin
            n_s24 = Q15_MINUS_ONE;
        end else if (r_ge23) begin
            n_s24 = Q15_PLUS_ONE;
        end else if (n_delta[DELTA_W-1:Q15_W] != '0) begin
            n_s24 = Q15_MINUS_ONE;
        end else if (n_delta == '0) begin
            n_s24 = Q15_PLUS_ONE;
        end else begin
            n_s24 = Q15_W'((Q15_W+1)'(32768) - (Q15_W+1)'(n_delta));
        end
    end

    always_ff @(posedge i_clk) begin
        r_c22  <= r_sc[LOG_STEPS];
        r_z22  <= r_sz[LOG_STEPS];
        r_ge22 <= (n_l2 >= n_ref);
        r_t22  <= n_ref - n_l2;

        r_c23    <= r_c22;
        r_z23    <= r_z22;
        r_ge23   <= r_ge22;
        r_prod23 <= PROD_W'(r_t22) * PROD_W'(LOG_COEF);

        r_c24 <= r_c23;
        r_s24 <= n_s24;
    end

    assign o_ahead_valid = r_v23;
    assign o_ahead_ctl   = r_c23;
    assign o_valid       = r_v24;
    assign o_ctl         = r_c24;
    assign o_scaled      = r_s24;

endmodule

`default_nettype wire

// File: src/sbdph_fifo.sv
// Output queue that holds finished result items until the sink takes them.
`timescale 1ns / 1ps
`default_nettype none

module sbdph_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [sbdph_pkg::OUT_W-1:0]   i_data,
    input  wire logic                          i_pop,
    output logic      [sbdph_pkg::OUT_W-1:0]   o_data,
    output sbdph_pkg::t_fifo_stat              o_stat
);

    import sbdph_pkg::*;

    logic [OUT_W-1:0]   r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [USED_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + USED_W'(i_push) - USED_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == USED_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

// File: src/spectrum_bin_db_peak_hold.sv
// Top level: per-bin dB level with decaying smoothing and peak hold.
// Each result item passes the dB pipeline and the bin update into the output queue.
// Throughput: one item per cycle; the 32-entry output queue and the in-flight
// count set how far the sink may fall behind before s_axis_tready drops.
// Reset: configuration returns to its defaults, then a clearing pass writes -1 into
// every level and peak entry; no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bin_db_peak_hold #(
    parameter int BIN_COUNT    = 1024,
    parameter int SAMPLE_WIDTH = 24,
    localparam int IN_BITS     = sbdph_pkg::IDX_W + 2 * SAMPLE_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input items
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // bin_index, bin_real, bin_imag from the lowest bit up
    input  wire logic [IN_TDATA_W-1:0]                 s_axis_tdata,
    // mode
    input  wire logic                                  s_axis_tuser,
    // Result items
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // out_index, level, peak from the lowest bit up
    output logic [sbdph_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // Configuration writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [sbdph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [sbdph_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import sbdph_pkg::*;

    localparam int AW = $clog2(BIN_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BIN_COUNT - 1);
    localparam logic [16:0]   BIN_LIMIT = 17'(BIN_COUNT);

    // Configuration
    logic                  r_smooth;
    logic [FFT_LOG2_W-1:0] r_fft_log2;
    logic [DECAY_W-1:0]    r_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth   <= RST_SMOOTH;
            r_fft_log2 <= RST_FFT_LOG2;
            r_decay    <= RST_DECAY;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SMOOTH:   r_smooth   <= i_cfg_data[0];
                CFG_FFT_LOG2: r_fft_log2 <= i_cfg_data[FFT_LOG2_W-1:0];
                CFG_DECAY:    r_decay    <= i_cfg_data[DECAY_W-1:0];
                default:      ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clearing pass after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Admission: items in the pipeline plus items in the queue never exceed its depth
    logic              r_used;
    logic [USED_W-1:0] r_used_cnt;
    logic              in_acc, out_pop;

    assign s_axis_tready = !r_clearing && (r_used_cnt < USED_W'(FIFO_DEPTH));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_cnt <= '0;
            r_used     <= 1'b0;
        end else begin
            r_used_cnt <= r_used_cnt + USED_W'(in_acc) - USED_W'(out_pop);
            r_used     <= (r_used_cnt != '0);
        end
    end

    // dB conversion
    t_ctl in_ctl;
    logic ahead_valid, res_valid;
    t_ctl ahead_ctl, res_ctl;
    logic signed [Q15_W-1:0] res_scaled;

    assign in_ctl.mode = s_axis_tuser;
    assign in_ctl.idx  = s_axis_tdata[IDX_W-1:0];

    sbdph_db #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_db (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_acc),
        .i_ctl         (in_ctl),
        .i_re          (s_axis_tdata[IDX_W +: SAMPLE_WIDTH]),
        .i_im          (s_axis_tdata[IDX_W + SAMPLE_WIDTH +: SAMPLE_WIDTH]),
        .i_fft_log2    (r_fft_log2),
        .o_ahead_valid (ahead_valid),
        .o_ahead_ctl   (ahead_ctl),
        .o_valid       (res_valid),
        .o_ctl         (res_ctl),
        .o_scaled      (res_scaled)
    );

    // Level and peak stores: read one stage ahead, update and write back
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [Q15_W-1:0]        lvl_wdata, pk_wdata;
    logic [Q15_W-1:0]        lvl_rdata, pk_rdata;

    sbdph_ram #(
        .WIDTH (Q15_W),
        .DEPTH (BIN_COUNT)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (ahead_valid),
        .i_raddr (AW'(ahead_ctl.idx)),
        .o_rdata (lvl_rdata)
    );

    sbdph_ram #(
        .WIDTH (Q15_W),
        .DEPTH (BIN_COUNT)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (pk_wdata),
        .i_re    (ahead_valid),
        .i_raddr (AW'(ahead_ctl.idx)),
        .o_rdata (pk_rdata)
    );

    // The entry written at the edge of the read is not yet in the read data.
    logic                    r_fwd_valid;
    logic [AW-1:0]           r_fwd_addr;
    logic signed [Q15_W-1:0] r_fwd_lvl, r_fwd_pk;

    logic [AW-1:0]           cur_addr;
    logic                    cur_in_range, item_we;
    logic signed [Q15_W-1:0] old_lvl, old_pk, new_lvl, new_pk, out_lvl, out_pk;
    logic signed [Q15_W:0]   decayed, s_ext;

    always_comb begin
        cur_addr     = AW'(res_ctl.idx);
        cur_in_range = (17'(res_ctl.idx) < BIN_LIMIT);
        item_we      = res_valid && cur_in_range;

        if (r_fwd_valid && (r_fwd_addr == cur_addr)) begin
            old_lvl = r_fwd_lvl;
            old_pk  = r_fwd_pk;
        end else begin
            old_lvl = lvl_rdata;
            old_pk  = pk_rdata;
        end

        s_ext   = {res_scaled[Q15_W-1], res_scaled};
        decayed = {old_lvl[Q15_W-1], old_lvl} - $signed({2'b00, r_decay});

        if (res_ctl.mode) begin
            new_lvl = old_lvl;
            new_pk  = Q15_MINUS_ONE;
        end else begin
            if (!r_smooth) begin
                new_lvl = res_scaled;
            end else if (s_ext > decayed) begin
                new_lvl = res_scaled;
            end else begin
                new_lvl = decayed[Q15_W-1:0];
            end
            new_pk = (res_scaled > old_pk) ? res_scaled : old_pk;
        end

        out_lvl = cur_in_range ? new_lvl : Q15_MINUS_ONE;
        out_pk  = cur_in_range ? new_pk  : Q15_MINUS_ONE;

        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            lvl_wdata = Q15_MINUS_ONE;
            pk_wdata  = Q15_MINUS_ONE;
        end else begin
            mem_we    = item_we;
            mem_waddr = cur_addr;
            lvl_wdata = new_lvl;
            pk_wdata  = new_pk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= item_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= cur_addr;
        r_fwd_lvl  <= new_lvl;
        r_fwd_pk   <= new_pk;
    end

    // Result queue
    t_fifo_stat       fifo_stat;
    logic [OUT_W-1:0] fifo_rdata;

    sbdph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({out_pk, out_lvl, res_ctl.idx}),
        .i_pop   (out_pop),
        .o_data  (fifo_rdata),
        .o_stat  (fifo_stat)
    );

    assign m_axis_tvalid = !fifo_stat.empty;
    assign m_axis_tdata  = OUT_TDATA_W'(fifo_rdata);

    // Checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= USED_W'(FIFO_DEPTH))
        else $error("in-flight count exceeds queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !fifo_stat.full)
        else $error("result pushed into a full queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_pop && !in_acc) |=> (r_used_cnt == $past(r_used_cnt) - 1'b1))
        else $error("in-flight count not lowered on delivery");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_used && !res_valid))
        else $error("item in flight during clearing pass");

endmodule

`default_nettype wire
